// ----- sv/gals_pkg.sv -----
`default_nettype none

package gals_pkg;

    // Grid geometry and area limit.
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int MAX_AREA    = 8;

    // Field widths of the item ports.
    localparam int COORD_W = 6;
    localparam int SIZE_W  = 4;
    localparam int FLAG_W  = 5;

    // Grid store.
    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Wide enough to compare a coordinate plus a size against the grid edge.
    localparam int EXT_W = 9;

    // Fixed-point ray arithmetic, 16 fractional bits.
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ACC_W     = COORD_W + FRAC_W + 1;
    localparam int SLOPE_W   = FRAC_W + 2;
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    localparam logic [FRAC_W-1:0] FIX_HALF = FRAC_W'(32768);

    // Blocking flag bits of one tile.
    localparam logic [FLAG_W-1:0] FLAG_FULL  = 5'b00001;
    localparam logic [FLAG_W-1:0] FLAG_NORTH = 5'b00010;
    localparam logic [FLAG_W-1:0] FLAG_EAST  = 5'b00100;
    localparam logic [FLAG_W-1:0] FLAG_SOUTH = 5'b01000;
    localparam logic [FLAG_W-1:0] FLAG_WEST  = 5'b10000;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_ORIENT,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } gals_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              clear_en;
        logic [ADDR_W-1:0] clear_addr;
        logic              tile_write;
        logic              load;
        logic              prep;
        logic              orient;
        logic              div_step;
        logic              walk_step;
        logic              load_result;
        logic              result_bit;
    } gals_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic same;
        logic start_full;
        logic div_last;
        logic hit;
        logic walk_clear;
    } gals_status_t;

endpackage

`default_nettype wire

// ----- sv/grid_area_line_of_sight.sv -----
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// in        input      in_valid / in_ready  kind, src_x, src_y, src_side, dst_x, dst_y,
//                                           dst_side, tile_flags
// out       output     out_valid/out_ready  visible (one beat per query, none per write)
//
// A tile write is taken in the idle state. A query runs setup, a restoring slope
// divider, then one tile pair read per cycle from the dual-read grid memory.
// Sizes of zero or over MAX_AREA and areas off the grid skip the divider and walk.
// After reset the grid memory is cleared one tile a cycle, while in_ready stays
// low. A result that is not taken holds the next query in its final state; new
// items are still accepted while a result beat waits.

module grid_area_line_of_sight
    import gals_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic [COORD_W-1:0] src_x,
    input  wire logic [COORD_W-1:0] src_y,
    input  wire logic [SIZE_W-1:0]  src_side,
    input  wire logic [COORD_W-1:0] dst_x,
    input  wire logic [COORD_W-1:0] dst_y,
    input  wire logic [SIZE_W-1:0]  dst_side,
    input  wire logic [FLAG_W-1:0]  tile_flags,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    visible
);

    gals_cmd_t    cmd;
    gals_status_t status;

    gals_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gals_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_side   (src_side),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .dst_side   (dst_side),
        .tile_flags (tile_flags),
        .status     (status),
        .visible    (visible)
    );

    // A query keeps the input closed on the following cycle.
    a_query_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_QUERY)) |=> !in_ready)
        else $error("input still open after a query beat");

    // A result beat only appears from the final state of a query.
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat raised while the input was open");

    // A blocked tile is only seen while a query is in progress.
    a_hit_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        status.hit |-> !in_ready)
        else $error("blocking hit reported outside a query");

endmodule

`default_nettype wire

// ----- sv/gals_grid_mem.sv -----
`default_nettype none

module gals_grid_mem
    import gals_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [FLAG_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [FLAG_W-1:0] rd_data_a,
    output logic      [FLAG_W-1:0] rd_data_b
);

    logic [FLAG_W-1:0] grid_reg [DEPTH];
    logic [FLAG_W-1:0] rd_data_a_reg;
    logic [FLAG_W-1:0] rd_data_b_reg;

    // One write port and two read ports with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= grid_reg[rd_addr_a];
        rd_data_b_reg <= grid_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

// ----- sv/gals_datapath.sv -----
`default_nettype none

module gals_datapath
    import gals_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gals_cmd_t          cmd,
    input  wire logic [COORD_W-1:0] src_x,
    input  wire logic [COORD_W-1:0] src_y,
    input  wire logic [SIZE_W-1:0]  src_side,
    input  wire logic [COORD_W-1:0] dst_x,
    input  wire logic [COORD_W-1:0] dst_y,
    input  wire logic [SIZE_W-1:0]  dst_side,
    input  wire logic [FLAG_W-1:0]  tile_flags,
    output gals_status_t            status,
    output logic                    visible
);

    // Row-major tile address.
    function automatic logic [ADDR_W-1:0] tile_addr(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        return ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(x);
    endfunction

    // Coordinate of an area that lies nearest to the other anchor.
    function automatic logic [COORD_W-1:0] nearest(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] o,
        input logic [SIZE_W-1:0]  s
    );
        logic [EXT_W-1:0] e;
        e = EXT_W'(a) + EXT_W'(s) - EXT_W'(1);
        if (a >= o)
        begin
            return a;
        end
        else if (e <= EXT_W'(o))
        begin
            return COORD_W'(e);
        end
        return o;
    endfunction

    // Latched query fields.
    logic [COORD_W-1:0] sx_reg, sy_reg, tx_reg, ty_reg;
    logic [SIZE_W-1:0]  ss_reg, ts_reg;

    // Chosen endpoints and validity.
    logic               bad_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;

    // Walk state.
    logic               xmaj_reg;
    logic               dir_neg_reg;
    logic               min_neg_reg;
    logic [COORD_W-1:0] maj_reg;
    logic [COORD_W-1:0] maj_end_reg;
    logic [COORD_W-1:0] min_end_reg;
    logic [FLAG_W-1:0]  maj_mask_reg;
    logic [FLAG_W-1:0]  min_mask_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Slope divider.
    logic [COORD_W-1:0]   den_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic                 q_top_reg;
    logic [FRAC_W-1:0]    q_lo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Check in flight and start tile capture.
    logic              chk_valid_reg;
    logic              chk_last_reg;
    logic              issued_last_reg;
    logic              start_pend_reg;
    logic              start_full_reg;
    logic [FLAG_W-1:0] chk_mask_a_reg;
    logic [FLAG_W-1:0] chk_mask_b_reg;
    logic              visible_reg;

    // Memory ports.
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [FLAG_W-1:0] mem_wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [FLAG_W-1:0] rd_data_a;
    logic [FLAG_W-1:0] rd_data_b;

    // Combinational helpers.
    logic                     in_grid;
    logic                     bad_c;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [COORD_W-1:0]       adx, ady;
    logic                     xmaj_c;
    logic [COORD_W-1:0]       maj_abs, min_abs;
    logic [FLAG_W-1:0]        xf, yf;
    logic [COORD_W-1:0]       min_start;
    logic                     min_neg_c;
    logic [COORD_W:0]         rem2, rem_sub;
    logic                     ge;
    logic [SLOPE_W-1:0]       quo_mag;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ACC_W-1:0]  acc_n;
    logic [COORD_W-1:0]       maj_new, fl, nfl;
    logic                     last_c;
    logic [FLAG_W-1:0]        mask_a_c, mask_b_c;
    logic                     step_fire;
    logic [ADDR_W-1:0]        walk_addr_a, walk_addr_b;

    // Tile writes and the clearing sweep share the write port.
    always_comb
    begin
        in_grid = (EXT_W'(src_x) < EXT_W'(GRID_WIDTH)) &&
                  (EXT_W'(src_y) < EXT_W'(GRID_HEIGHT));
        mem_wr_en   = cmd.clear_en | (cmd.tile_write & in_grid);
        mem_wr_addr = cmd.clear_en ? cmd.clear_addr : tile_addr(src_x, src_y);
        mem_wr_data = cmd.clear_en ? '0 : tile_flags;
    end

    // Area checks against size limits and the grid edge.
    always_comb
    begin
        bad_c = (ss_reg == '0) || (ts_reg == '0) ||
                (EXT_W'(ss_reg) > EXT_W'(MAX_AREA)) ||
                (EXT_W'(ts_reg) > EXT_W'(MAX_AREA)) ||
                (EXT_W'(sx_reg) + EXT_W'(ss_reg) > EXT_W'(GRID_WIDTH)) ||
                (EXT_W'(sy_reg) + EXT_W'(ss_reg) > EXT_W'(GRID_HEIGHT)) ||
                (EXT_W'(tx_reg) + EXT_W'(ts_reg) > EXT_W'(GRID_WIDTH)) ||
                (EXT_W'(ty_reg) + EXT_W'(ts_reg) > EXT_W'(GRID_HEIGHT));
    end

    // Direction, major axis and side masks of the ray.
    always_comb
    begin
        dx  = signed'({1'b0, x1_reg}) - signed'({1'b0, x0_reg});
        dy  = signed'({1'b0, y1_reg}) - signed'({1'b0, y0_reg});
        adx = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ady = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
        xmaj_c    = adx > ady;
        maj_abs   = xmaj_c ? adx : ady;
        min_abs   = xmaj_c ? ady : adx;
        min_start = xmaj_c ? y0_reg : x0_reg;
        min_neg_c = xmaj_c ? dy[DIFF_W-1] : dx[DIFF_W-1];
        xf = FLAG_FULL | (dx[DIFF_W-1] ? FLAG_EAST : FLAG_WEST);
        yf = FLAG_FULL | (dy[DIFF_W-1] ? FLAG_NORTH : FLAG_SOUTH);
    end

    // One restoring division step per cycle.
    always_comb
    begin
        rem2    = {rem_reg, 1'b0};
        ge      = rem2 >= {1'b0, den_reg};
        rem_sub = rem2 - {1'b0, den_reg};
        quo_mag = {1'b0, q_top_reg, q_lo_reg};
        slope   = min_neg_reg ? -signed'(quo_mag) : signed'(quo_mag);
    end

    // Next tile pair along the ray, with the target tile's full flag masked.
    always_comb
    begin
        maj_new = dir_neg_reg ? maj_reg - COORD_W'(1) : maj_reg + COORD_W'(1);
        acc_n   = acc_reg + ACC_W'(slope);
        fl      = acc_reg[FRAC_W +: COORD_W];
        nfl     = acc_n[FRAC_W +: COORD_W];
        last_c  = maj_new == maj_end_reg;
        mask_a_c = maj_mask_reg &
                   ~((last_c && (fl == min_end_reg)) ? FLAG_FULL : '0);
        mask_b_c = (nfl != fl) ?
                   (min_mask_reg &
                    ~((last_c && (nfl == min_end_reg)) ? FLAG_FULL : '0)) : '0;
        walk_addr_a = xmaj_reg ? tile_addr(maj_new, fl) : tile_addr(fl, maj_new);
        walk_addr_b = xmaj_reg ? tile_addr(maj_new, nfl) : tile_addr(nfl, maj_new);
        step_fire   = cmd.walk_step && !issued_last_reg;
    end

    // Read port A fetches the start tile first, then both ports follow the ray.
    always_comb
    begin
        rd_addr_a = cmd.orient ? tile_addr(x0_reg, y0_reg) : walk_addr_a;
        rd_addr_b = walk_addr_b;
    end

    // Payload registers of the query.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg <= src_x;
            sy_reg <= src_y;
            ss_reg <= src_side;
            tx_reg <= dst_x;
            ty_reg <= dst_y;
            ts_reg <= dst_side;
        end
        if (cmd.prep)
        begin
            bad_reg <= bad_c;
            x0_reg  <= nearest(sx_reg, tx_reg, ss_reg);
            y0_reg  <= nearest(sy_reg, ty_reg, ss_reg);
            x1_reg  <= nearest(tx_reg, sx_reg, ts_reg);
            y1_reg  <= nearest(ty_reg, sy_reg, ts_reg);
        end
        if (cmd.orient)
        begin
            xmaj_reg     <= xmaj_c;
            dir_neg_reg  <= xmaj_c ? dx[DIFF_W-1] : dy[DIFF_W-1];
            min_neg_reg  <= min_neg_c;
            maj_reg      <= xmaj_c ? x0_reg : y0_reg;
            maj_end_reg  <= xmaj_c ? x1_reg : y1_reg;
            min_end_reg  <= xmaj_c ? y1_reg : x1_reg;
            maj_mask_reg <= xmaj_c ? xf : yf;
            min_mask_reg <= xmaj_c ? yf : xf;
            acc_reg      <= signed'({1'b0, min_start, FIX_HALF}) -
                            ACC_W'({1'b0, min_neg_c});
            den_reg      <= maj_abs;
            rem_reg      <= (min_abs == maj_abs) ? '0 : min_abs;
            q_top_reg    <= min_abs == maj_abs;
            q_lo_reg     <= '0;
            div_cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= ge ? COORD_W'(rem_sub) : COORD_W'(rem2);
            q_lo_reg    <= {q_lo_reg[FRAC_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (step_fire)
        begin
            maj_reg        <= maj_new;
            acc_reg        <= acc_n;
            chk_mask_a_reg <= mask_a_c;
            chk_mask_b_reg <= mask_b_c;
            chk_last_reg   <= last_c;
        end
        if (start_pend_reg)
        begin
            start_full_reg <= |(rd_data_a & FLAG_FULL);
        end
        if (cmd.load_result)
        begin
            visible_reg <= cmd.result_bit;
        end
    end

    // Control flags of the walk pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg   <= 1'b0;
            issued_last_reg <= 1'b0;
            start_pend_reg  <= 1'b0;
        end
        else
        begin
            chk_valid_reg  <= step_fire;
            start_pend_reg <= cmd.orient;
            if (cmd.orient)
            begin
                issued_last_reg <= 1'b0;
            end
            else if (step_fire)
            begin
                issued_last_reg <= last_c;
            end
        end
    end

    gals_grid_mem u_grid_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Status back to the controller.
    always_comb
    begin
        status.bad        = bad_reg;
        status.same       = (x0_reg == x1_reg) && (y0_reg == y1_reg);
        status.start_full = start_full_reg;
        status.div_last   = div_cnt_reg == DIV_CNT_W'(FRAC_W - 1);
        status.hit        = chk_valid_reg &&
                            (|((rd_data_a & chk_mask_a_reg) |
                               (rd_data_b & chk_mask_b_reg)));
        status.walk_clear = chk_valid_reg && chk_last_reg;
    end

    assign visible = visible_reg;

endmodule

`default_nettype wire

// ----- sv/gals_ctrl.sv -----
`default_nettype none

module gals_ctrl
    import gals_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         kind,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire gals_status_t status,
    output gals_cmd_t         cmd
);

    gals_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.clear_addr = clr_cnt_reg;
        cmd.result_bit = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        cmd.tile_write = 1'b1;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_ORIENT;
            end
            ST_ORIENT:
            begin
                cmd.orient = 1'b1;
                if (status.bad)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (status.same)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    if (status.start_full)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.hit)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (status.walk_clear)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- verif/grid_area_line_of_sight_test.sv -----
`timescale 1ns / 100ps

module grid_area_line_of_sight_test;
    import gals_pkg::*;

    localparam int CLK_PERIOD_NS = 4;
    localparam int FIX_ONE       = 1 << FRAC_W;
    localparam int HALF_TILE     = int'(FIX_HALF);
    localparam int RANDOM_ITEMS  = 1400;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int WINDOW_LO     = 16;
    localparam int WINDOW_HI     = 40;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [FLAG_W-1:0] ALL_FLAGS =
        FLAG_FULL | FLAG_NORTH | FLAG_EAST | FLAG_SOUTH | FLAG_WEST;

    // One input beat, field for field.
    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [SIZE_W-1:0]  ss;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [SIZE_W-1:0]  ts;
        logic [FLAG_W-1:0]  flags;
    } sight_item_t;

    // Predicted answer of one query, with its position in the query stream.
    typedef struct {
        bit vis;
        int seq;
    } verdict_t;

    // Keeps a copy of the blocker grid and the answers still owed by the block.
    class sight_scoreboard;
        logic [FLAG_W-1:0] tiles [DEPTH];
        verdict_t          verdicts [$];
        int                mismatches;
        int                writes;
        int                queries;
        int                rejected;
        int                clear_paths;
        int                blocked_paths;

        function new();
            foreach (tiles[i])
                tiles[i] = '0;
        endfunction

        function logic [FLAG_W-1:0] flags_at(int x, int y);
            if (x < 0 || y < 0 || x >= GRID_WIDTH || y >= GRID_HEIGHT)
                return '0;
            return tiles[y * GRID_WIDTH + x];
        endfunction

        // The tile of an area that lies nearest the other area on one axis.
        function int nearest_corner(int anchor, int other, int size);
            if (anchor >= other)
                return anchor;
            if (anchor + size - 1 <= other)
                return anchor + size - 1;
            return other;
        endfunction

        // Walks the ray along its major axis, the minor coordinate in 16.16 form.
        function bit ray_is_clear(int x0, int y0, int x1, int y1);
            int                dx;
            int                dy;
            int                adx;
            int                ady;
            int                pos;
            int                acc;
            int                slope;
            int                dir;
            int                cur;
            int                nxt;
            logic [FLAG_W-1:0] xmask;
            logic [FLAG_W-1:0] ymask;
            logic [FLAG_W-1:0] m;

            dx    = x1 - x0;
            dy    = y1 - y0;
            adx   = (dx < 0) ? -dx : dx;
            ady   = (dy < 0) ? -dy : dy;
            xmask = FLAG_FULL | ((dx < 0) ? FLAG_EAST : FLAG_WEST);
            ymask = FLAG_FULL | ((dy < 0) ? FLAG_NORTH : FLAG_SOUTH);

            if (x0 == x1 && y0 == y1)
                return 1'b1;
            if ((flags_at(x0, y0) & FLAG_FULL) != '0)
                return 1'b0;

            if (adx > ady)
            begin
                pos   = x0;
                acc   = y0 * FIX_ONE + HALF_TILE - ((dy < 0) ? 1 : 0);
                slope = (dy * FIX_ONE) / adx;
                dir   = (dx < 0) ? -1 : 1;
                while (pos != x1)
                begin
                    pos += dir;
                    cur = acc >>> FRAC_W;
                    m   = xmask;
                    if (pos == x1 && cur == y1)
                        m &= ~FLAG_FULL;
                    if ((flags_at(pos, cur) & m) != '0)
                        return 1'b0;
                    acc += slope;
                    nxt = acc >>> FRAC_W;
                    m   = ymask;
                    if (pos == x1 && nxt == y1)
                        m &= ~FLAG_FULL;
                    if (nxt != cur && (flags_at(pos, nxt) & m) != '0)
                        return 1'b0;
                end
            end
            else
            begin
                pos   = y0;
                acc   = x0 * FIX_ONE + HALF_TILE - ((dx < 0) ? 1 : 0);
                slope = (dx * FIX_ONE) / ady;
                dir   = (dy < 0) ? -1 : 1;
                while (pos != y1)
                begin
                    pos += dir;
                    cur = acc >>> FRAC_W;
                    m   = ymask;
                    if (cur == x1 && pos == y1)
                        m &= ~FLAG_FULL;
                    if ((flags_at(cur, pos) & m) != '0)
                        return 1'b0;
                    acc += slope;
                    nxt = acc >>> FRAC_W;
                    m   = xmask;
                    if (nxt == x1 && pos == y1)
                        m &= ~FLAG_FULL;
                    if (nxt != cur && (flags_at(nxt, pos) & m) != '0)
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Applies a write to the grid copy, or works out the answer to a query.
        function void note_input(sight_item_t it);
            int       sx;
            int       sy;
            int       ss;
            int       tx;
            int       ty;
            int       ts;
            verdict_t v;

            sx = it.sx;
            sy = it.sy;
            ss = it.ss;
            tx = it.tx;
            ty = it.ty;
            ts = it.ts;

            if (it.kind == KIND_WRITE)
            begin
                writes++;
                if (sx < GRID_WIDTH && sy < GRID_HEIGHT)
                    tiles[sy * GRID_WIDTH + sx] = it.flags;
                return;
            end

            queries++;
            v.seq = queries;
            if (ss == 0 || ts == 0 || ss > MAX_AREA || ts > MAX_AREA ||
                sx + ss > GRID_WIDTH || sy + ss > GRID_HEIGHT ||
                tx + ts > GRID_WIDTH || ty + ts > GRID_HEIGHT)
            begin
                v.vis = 1'b0;
                rejected++;
            end
            else
            begin
                v.vis = ray_is_clear(nearest_corner(sx, tx, ss), nearest_corner(sy, ty, ss),
                                     nearest_corner(tx, sx, ts), nearest_corner(ty, sy, ts));
                if (v.vis)
                    clear_paths++;
                else
                    blocked_paths++;
            end
            verdicts.push_back(v);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Compares one result beat with the oldest answer still owed.
        task check_result(logic vis);
            verdict_t v;

            if (verdicts.size() == 0)
            begin
                report_mismatch($sformatf("visible=%0b with no query outstanding", vis));
                return;
            end
            v = verdicts.pop_front();
            if (vis !== v.vis)
                report_mismatch($sformatf("query %0d: visible=%0b, predicted %0b",
                                          v.seq, vis, v.vis));
        endtask
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               kind       = KIND_WRITE;
    logic [COORD_W-1:0] src_x      = '0;
    logic [COORD_W-1:0] src_y      = '0;
    logic [SIZE_W-1:0]  src_side   = '0;
    logic [COORD_W-1:0] dst_x      = '0;
    logic [COORD_W-1:0] dst_y      = '0;
    logic [SIZE_W-1:0]  dst_side   = '0;
    logic [FLAG_W-1:0]  tile_flags = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               visible;

    sight_scoreboard sb = new();
    bit              hold_request;
    int              long_holds;

    grid_area_line_of_sight u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_side   (src_side),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .dst_side   (dst_side),
        .tile_flags (tile_flags),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .visible    (visible)
    );

    always #(CLK_PERIOD_NS / 2) clk = ~clk;

    function automatic sight_item_t make_query(int sx, int sy, int ss, int tx, int ty, int ts);
        sight_item_t it;

        it.kind  = KIND_QUERY;
        it.sx    = COORD_W'(sx);
        it.sy    = COORD_W'(sy);
        it.ss    = SIZE_W'(ss);
        it.tx    = COORD_W'(tx);
        it.ty    = COORD_W'(ty);
        it.ts    = SIZE_W'(ts);
        it.flags = FLAG_W'($urandom);
        return it;
    endfunction

    function automatic sight_item_t make_write(int x, int y, logic [FLAG_W-1:0] flags);
        sight_item_t it;

        it       = make_query(x, y, $urandom_range(0, 15), $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 15));
        it.kind  = KIND_WRITE;
        it.flags = flags;
        return it;
    endfunction

    // West or south edge of an area, either anywhere on the grid or in the busy window.
    function automatic int pick_corner(int size, int limit, bit grouped);
        if (grouped)
            return $urandom_range(WINDOW_LO, WINDOW_HI - size);
        return $urandom_range(0, limit - size);
    endfunction

    // Mostly well-formed queries and writes clustered in one window, with some noise.
    function automatic sight_item_t random_item();
        sight_item_t it;
        int          pick;
        int          ss;
        int          ts;
        bit          grouped;

        pick = $urandom_range(0, 19);
        it   = make_query($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                          $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15));
        if (pick < 6)
        begin
            it.kind = KIND_WRITE;
            if ($urandom_range(0, 1) == 1)
            begin
                it.sx = COORD_W'($urandom_range(WINDOW_LO, WINDOW_HI - 1));
                it.sy = COORD_W'($urandom_range(WINDOW_LO, WINDOW_HI - 1));
            end
            if ($urandom_range(0, 5) == 0)
                it.flags = '0;
            return it;
        end
        if (pick < 18)
        begin
            ss      = $urandom_range(1, MAX_AREA);
            ts      = $urandom_range(1, MAX_AREA);
            grouped = ($urandom_range(0, 1) == 1);
            it.ss   = SIZE_W'(ss);
            it.ts   = SIZE_W'(ts);
            it.sx   = COORD_W'(pick_corner(ss, GRID_WIDTH, grouped));
            it.sy   = COORD_W'(pick_corner(ss, GRID_HEIGHT, grouped));
            it.tx   = COORD_W'(pick_corner(ts, GRID_WIDTH, grouped));
            it.ty   = COORD_W'(pick_corner(ts, GRID_HEIGHT, grouped));
        end
        return it;
    endfunction

    // Offers one beat and holds it until the block takes it; valid stays high afterwards.
    task automatic send_item(sight_item_t it);
        in_valid   <= 1'b1;
        kind       <= it.kind;
        src_x      <= it.sx;
        src_y      <= it.sy;
        src_side   <= it.ss;
        dst_x      <= it.tx;
        dst_y      <= it.ty;
        dst_side   <= it.ts;
        tile_flags <= it.flags;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_input(it);
    endtask

    // Result side: short stalls, long ready stretches, and on request one long hold-off.
    initial
    begin : result_receiver
        int mode;
        int span;
        bit take;

        forever
        begin
            mode = $urandom_range(0, 9);
            if (hold_request)
            begin
                hold_request = 1'b0;
                long_holds++;
                take = 1'b0;
                span = LONG_HOLD;
            end
            else if (mode < 3)
            begin
                take = 1'b0;
                span = $urandom_range(1, 12);
            end
            else if (mode == 3)
            begin
                take = 1'b1;
                span = $urandom_range(50, 200);
            end
            else
            begin
                take = 1'b1;
                span = $urandom_range(1, 8);
            end
            out_ready <= take;
            repeat (span) @(posedge clk);
        end
    end

    // Every result beat taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result(visible);
    end

    initial
    begin : stimulus
        int burst_left;
        int gap;
        int waited;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats: rejected areas, grid corners and each blocking rule.
        send_item(make_query(10, 10, 1, 10, 10, 1));          // both areas on one tile
        send_item(make_query(10, 10, 0, 20, 20, 3));          // empty source area
        send_item(make_query(10, 10, 2, 20, 20, 0));          // empty target area
        send_item(make_query(10, 10, 9, 20, 20, 1));          // source too large
        send_item(make_query(10, 10, 1, 20, 20, 15));         // target too large
        send_item(make_query(60, 10, 8, 20, 20, 1));          // source past the east edge
        send_item(make_query(10, 10, 1, 20, 63, 2));          // target past the north edge
        send_item(make_query(0, 0, 8, 56, 56, 8));            // largest areas, far corners
        send_item(make_query(63, 0, 1, 0, 63, 1));            // long diagonal
        send_item(make_write(0, 0, '0));
        send_item(make_write(63, 63, ALL_FLAGS));
        send_item(make_query(0, 0, 1, 63, 63, 1));            // target sides block
        send_item(make_write(20, 20, FLAG_FULL));
        send_item(make_query(18, 20, 1, 22, 20, 1));          // full tile on the way
        send_item(make_query(20, 20, 1, 25, 20, 1));          // full start tile
        send_item(make_query(15, 20, 1, 20, 20, 1));          // full target is ignored
        send_item(make_write(30, 40, FLAG_WEST));
        send_item(make_query(26, 40, 1, 30, 40, 1));          // enters target from the west
        send_item(make_query(34, 40, 1, 30, 40, 1));          // enters from the east, clear
        send_item(make_write(30, 44, FLAG_NORTH));
        send_item(make_query(30, 48, 1, 30, 41, 1));          // southward through a north side
        send_item(make_query(30, 41, 1, 30, 48, 1));          // northward, same tile is clear
        send_item(make_write(20, 20, '0));
        send_item(make_query(18, 20, 1, 22, 20, 1));          // wall removed again

        // Random beats in bursts, with a long output hold-off twice on the way.
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 150 || n == 800)
                hold_request = 1'b1;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_item(random_item());
            burst_left--;
        end
        in_valid <= 1'b0;

        // Drain the outstanding answers, then let the block settle.
        waited = 0;
        while (sb.verdicts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.verdicts.size() != 0)
            sb.report_mismatch($sformatf("%0d queries never answered", sb.verdicts.size()));

        $display("Run covered %0d tile writes and %0d queries: %0d clear, %0d blocked, %0d %s",
                 sb.writes, sb.queries, sb.clear_paths, sb.blocked_paths, sb.rejected,
                 "rejected.");
        $display("Output was held off for %0d cycles on %0d occasions with input %s",
                 LONG_HOLD, long_holds, "still offered.");
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/gals_pkg.sv
sv/gals_grid_mem.sv
sv/gals_datapath.sv
sv/gals_ctrl.sv
sv/grid_area_line_of_sight.sv
verif/grid_area_line_of_sight_test.sv
